### rtl/cda_pkg.sv
// shared types, constants and month table for the calendar date advance unit
`timescale 1ns / 1ps
`default_nettype none
package cda_pkg;

  localparam int unsigned CDA_YEAR_BITS = 16;

  localparam int unsigned RESET_YEAR  = 2021;
  localparam logic [3:0]  RESET_MONTH = 4'd9;
  localparam logic [4:0]  RESET_DAY   = 5'd2;

  localparam int unsigned YEAR_MOD        = 400;
  localparam int unsigned CENTURY         = 100;
  localparam int unsigned MONTHS_PER_YEAR = 12;

  // floor(x / 12) = (x * RECIP12) >> RECIP_SHIFT, exact for x below 2^17
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP12 = 17'd87382;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = CNT_W + RECIP_W;
  localparam int unsigned Q_W         = PROD_W - RECIP_SHIFT;

  // days still to add never exceed the count plus one month of overshoot
  localparam int unsigned LEFT_W = CNT_W + 1;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_DAYS   = 2'd1,
    ACT_MONTHS = 2'd2,
    ACT_YEARS  = 2'd3
  } cda_action_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cda_mod_sts_t;

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

### rtl/cda_in_if.sv
// command channel of the calendar date advance unit
`timescale 1ns / 1ps
`default_nettype none
interface cda_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [15:0] year_in;
  logic signed [4:0]  month_in;
  logic signed [5:0]  day_in;
  logic        [15:0] count;

  modport source (output valid, action, year_in, month_in, day_in, count, input ready);
  modport sink   (input valid, action, year_in, month_in, day_in, count, output ready);
endinterface
`default_nettype wire

### rtl/cda_out_if.sv
// date result channel of the calendar date advance unit
`timescale 1ns / 1ps
`default_nettype none
interface cda_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;

  modport source (output valid, year_out, month_out, day_out, input ready);
  modport sink   (input valid, year_out, month_out, day_out, output ready);
endinterface
`default_nettype wire

### rtl/calendar_date_advance_unit.sv
// Gregorian date keeper: set date, add days, add months, add years
// path from accept to result valid: set date and add years go from idle straight to emit, add months
// runs the reciprocal multiply state and the month state before emit, and add days waits in the
// mod state on the year mod 400 unit and then steps one month per cycle before emit
// one item at a time: the next item is taken once the result sits in the output register
// reset is asynchronous: date returns to 2021-09-02 and the output register empties
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_advance_unit
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_BITS = CDA_YEAR_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cda_in_if.sink    in_i,
  cda_out_if.source out_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_MONTHS = 6'b000100,
    ST_MOD    = 6'b001000,
    ST_STEP   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  localparam logic [YEAR_BITS-1:0] YEAR_RST = YEAR_BITS'(RESET_YEAR);

  state_e               state_q, state_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [3:0]           month_q, month_d;
  logic [4:0]           day_q, day_d;
  logic [LEFT_W-1:0]    left_q, left_d;
  logic [8:0]           yr400_q, yr400_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic                 ovalid_q, ovalid_d;
  logic [15:0]          oyear_q, oyear_d;
  logic [3:0]           omonth_q, omonth_d;
  logic [4:0]           oday_q, oday_d;

  logic         in_acc;
  logic         neg_load;
  logic         mod_start;
  cda_mod_sts_t mod_sts;
  logic [8:0]   mod_rem;

  // month step arithmetic
  logic [Q_W-1:0]    quot;
  logic [3:0]        rem12;
  logic [4:0]        msum;
  logic [4:0]        msum_m1;
  logic [Q_W-1:0]    yadd;

  // day step arithmetic
  logic              leap;
  logic              century;
  logic [4:0]        mlen;
  logic [LEFT_W:0]   dsum;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign neg_load = in_i.year_in[15] | in_i.month_in[4] | in_i.day_in[5];

  cda_yrmod #(
    .YEAR_BITS(YEAR_BITS)
  ) u_yrmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .year_i (year_q),
    .sts_o  (mod_sts),
    .rem_o  (mod_rem)
  );

  always_comb begin
    // count = 12 * quot + rem12, month + rem12 stays below 27
    quot    = prod_q[RECIP_SHIFT +: Q_W];
    rem12   = 4'(cnt_q - 16'({quot, 3'b000}) - 16'({quot, 2'b00}));
    msum    = {1'b0, month_q} + {1'b0, rem12};
    msum_m1 = msum - 5'd1;
    if (msum == 5'd0) begin
      yadd = (quot == '0) ? '0 : quot - Q_W'(1);
    end else if (msum_m1 >= 5'(2 * MONTHS_PER_YEAR)) begin
      yadd = quot + Q_W'(2);
    end else if (msum_m1 >= 5'(MONTHS_PER_YEAR)) begin
      yadd = quot + Q_W'(1);
    end else begin
      yadd = quot;
    end

    century = (yr400_q == 9'(CENTURY)) || (yr400_q == 9'(2 * CENTURY)) ||
              (yr400_q == 9'(3 * CENTURY));
    leap    = (year_q[1:0] == 2'b00) && !century;
    mlen    = month_days(leap, month_q);
    dsum    = (LEFT_W + 1)'(day_q) + (LEFT_W + 1)'(left_q);
  end

  always_comb begin
    state_d   = state_q;
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    left_d    = left_q;
    yr400_d   = yr400_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    ovalid_d  = ovalid_q;
    oyear_d   = oyear_q;
    omonth_d  = omonth_q;
    oday_d    = oday_q;
    mod_start = 1'b0;

    if (out_o.valid && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = in_i.count;
          case (cda_action_e'(in_i.action))
            ACT_SET: begin
              if (neg_load) begin
                year_d  = '0;
                month_d = '0;
                day_d   = '0;
              end else begin
                year_d  = YEAR_BITS'($unsigned(in_i.year_in));
                month_d = in_i.month_in[3:0];
                day_d   = in_i.day_in[4:0];
              end
              state_d = ST_EMIT;
            end
            ACT_DAYS: begin
              mod_start = 1'b1;
              left_d    = LEFT_W'(in_i.count);
              state_d   = ST_MOD;
            end
            ACT_MONTHS: begin
              state_d = ST_MUL;
            end
            ACT_YEARS: begin
              year_d  = year_q + YEAR_BITS'(in_i.count);
              state_d = ST_EMIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_d  = PROD_W'(cnt_q) * PROD_W'(RECIP12);
        state_d = ST_MONTHS;
      end
      ST_MONTHS: begin
        year_d = year_q + YEAR_BITS'(yadd);
        if (msum == 5'(MONTHS_PER_YEAR)) begin
          month_d = 4'(MONTHS_PER_YEAR);
        end else if (msum >= 5'(2 * MONTHS_PER_YEAR)) begin
          month_d = 4'(msum - 5'(2 * MONTHS_PER_YEAR));
        end else if (msum >= 5'(MONTHS_PER_YEAR)) begin
          month_d = 4'(msum - 5'(MONTHS_PER_YEAR));
        end else begin
          month_d = msum[3:0];
        end
        state_d = ST_EMIT;
      end
      ST_MOD: begin
        if (mod_sts.done) begin
          yr400_d = mod_rem;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (dsum <= (LEFT_W + 1)'(mlen)) begin
          day_d   = dsum[4:0];
          state_d = ST_EMIT;
        end else begin
          // jump to day 1 of the next month, overshoot past the month end goes back into the count
          left_d = LEFT_W'(dsum - (LEFT_W + 1)'(mlen) - (LEFT_W + 1)'(1));
          day_d  = 5'd1;
          if (month_q == 4'(MONTHS_PER_YEAR - 1)) begin
            month_d = 4'(MONTHS_PER_YEAR);
          end else if (month_q >= 4'(MONTHS_PER_YEAR)) begin
            month_d = month_q - 4'(MONTHS_PER_YEAR - 1);
          end else begin
            month_d = month_q + 4'd1;
          end
          if (month_q >= 4'(MONTHS_PER_YEAR)) begin
            year_d = year_q + YEAR_BITS'(1);
            // year wrap or the end of a 400 year cycle restarts the 400 year count at zero
            if (year_q == '1 || yr400_q == 9'(YEAR_MOD - 1)) begin
              yr400_d = '0;
            end else begin
              yr400_d = yr400_q + 9'd1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          oyear_d  = 16'(year_q);
          omonth_d = month_q;
          oday_d   = day_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      year_q   <= YEAR_RST;
      month_q  <= RESET_MONTH;
      day_q    <= RESET_DAY;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    yr400_q  <= yr400_d;
    cnt_q    <= cnt_d;
    prod_q   <= prod_d;
    oyear_q  <= oyear_d;
    omonth_q <= omonth_d;
    oday_q   <= oday_d;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.year_out  = oyear_q;
  assign out_o.month_out = omonth_q;
  assign out_o.day_out   = oday_q;

`ifndef SYNTH
  a_years_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.action == ACT_YEARS) |=>
      year_q == $past(year_q + YEAR_BITS'(in_i.count)))
    else $error("add years result wrong");

  a_mod_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD) |-> (mod_sts.busy || mod_sts.done))
    else $error("waiting on idle mod unit");

  a_yr400_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (yr400_q < 9'(YEAR_MOD)))
    else $error("year mod 400 out of range");

  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");
`endif

endmodule
`default_nettype wire

### rtl/cda_yrmod.sv
// year modulo 400 unit: reciprocal multiply for the quotient, then multiply back and subtract
`timescale 1ns / 1ps
`default_nettype none
module cda_yrmod
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_BITS = CDA_YEAR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [YEAR_BITS-1:0] year_i,
  output cda_mod_sts_t         sts_o,
  output logic [8:0]           rem_o
);

  // floor(y / 400) = floor((y >> 4) / 25), the quotient by 25 through a reciprocal
  localparam int unsigned M_W     = YEAR_BITS - 3;
  localparam int unsigned Y_SHIFT = YEAR_BITS + 1;
  localparam int unsigned YP_W    = 2 * YEAR_BITS - 7;
  localparam int unsigned YQ_W    = YEAR_BITS - 8;
  localparam logic [M_W-1:0] RECIP25 = M_W'(((64'd1 << Y_SHIFT) + 64'd24) / 64'd25);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [YEAR_BITS-1:0] yr_q, yr_d;
  logic [YP_W-1:0]      prod_q, prod_d;
  logic [8:0]           rem_q, rem_d;
  logic [YQ_W-1:0]      quot;
  logic [YEAR_BITS-1:0] quot_x400;

  // on start the year is multiplied by the reciprocal; while busy the quotient is multiplied back by 400 and subtracted
  always_comb begin
    quot      = prod_q[Y_SHIFT +: YQ_W];
    quot_x400 = YEAR_BITS'({quot, 8'b0}) + YEAR_BITS'({quot, 7'b0}) +
                YEAR_BITS'({quot, 4'b0});
    busy_d    = busy_q;
    done_d    = 1'b0;
    yr_d      = yr_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      yr_d   = year_i;
      prod_d = YP_W'(year_i[YEAR_BITS-1:4]) * YP_W'(RECIP25);
    end else if (busy_q) begin
      rem_d  = 9'(yr_q - quot_x400);
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    yr_q   <= yr_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign rem_o      = rem_q;

endmodule
`default_nettype wire
